// ----- hdl/scfp_pkg.sv -----
// Shared types, character codes and helper functions for the speed command frame parser.
package scfp_pkg;

	localparam int FRAME_MAX_DEF = 64;
	localparam int PART_MAX_DEF  = 9;

	localparam int CHAR_W  = 4;
	localparam int MAG_W   = 32;
	localparam int SCALE_W = 8;
	localparam int BYTE_W  = 8;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd10;

	localparam logic [BYTE_W-1:0] CH_V     = 8'h56;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		PH_LEFT    = 2'd0,
		PH_RIGHT   = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SC_BLANKS  = 2'd0,
		SC_DIGITS  = 2'd1,
		SC_STOPPED = 2'd2
	} scan_t;

	// result request from the parser to the scaling stage
	typedef struct packed {
		logic             valid;
		logic [MAG_W-1:0] left_mag;
		logic [MAG_W-1:0] right_mag;
		logic             left_fwd;
		logic             right_fwd;
	} emit_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
			(c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// v*10 + d, saturating at all ones
	function automatic logic [MAG_W-1:0] acc_digit(input logic [MAG_W-1:0] v,
		input logic [3:0] d);
		logic [MAG_W+3:0] t;
		t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{MAG_W{1'b0}}, d};
		return (t[MAG_W+3:MAG_W] != 4'd0) ? {MAG_W{1'b1}} : t[MAG_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] sat_mul(input logic [MAG_W-1:0] m,
		input logic [SCALE_W-1:0] s);
		logic [MAG_W+SCALE_W-1:0] p;
		p = {{SCALE_W{1'b0}}, m} * {{MAG_W{1'b0}}, s};
		return (p[MAG_W+SCALE_W-1:MAG_W] != '0) ? {MAG_W{1'b1}} : p[MAG_W-1:0];
	endfunction

endpackage

// ----- hdl/scfp_parser.sv -----
// Frame tracking and per-part number scanning, one byte per step.
module scfp_parser #(
	parameter int FRAME_MAX = scfp_pkg::FRAME_MAX_DEF,
	parameter int PART_MAX  = scfp_pkg::PART_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [scfp_pkg::BYTE_W-1:0] rx_byte,
	output scfp_pkg::emit_t             emit
);

	localparam int LEN_W = $clog2(FRAME_MAX);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(FRAME_MAX - 1);
	localparam logic [scfp_pkg::CHAR_W-1:0] PART_LIM = scfp_pkg::CHAR_W'(PART_MAX);
	localparam logic [scfp_pkg::CHAR_W-1:0] ONE_CHAR = scfp_pkg::CHAR_W'(1);

	logic [LEN_W-1:0]                len_q, len_d;
	scfp_pkg::phase_t                ph_q, ph_d;
	logic [scfp_pkg::MAG_W-1:0]      lval_q, lval_d, rval_q, rval_d;
	logic                            lneg_q, lneg_d, rneg_q, rneg_d;
	scfp_pkg::scan_t                 lscan_q, lscan_d, rscan_q, rscan_d;
	logic [scfp_pkg::CHAR_W-1:0]     lchars_q, lchars_d, rchars_q, rchars_d;
	logic                            c_digit;

	assign c_digit = scfp_pkg::is_digit(rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ph_q     <= scfp_pkg::PH_LEFT;
			lval_q   <= '0;
			lneg_q   <= 1'b0;
			lscan_q  <= scfp_pkg::SC_BLANKS;
			lchars_q <= '0;
			rval_q   <= '0;
			rneg_q   <= 1'b0;
			rscan_q  <= scfp_pkg::SC_DIGITS;
			rchars_q <= '0;
		end else if (step) begin
			len_q    <= len_d;
			ph_q     <= ph_d;
			lval_q   <= lval_d;
			lneg_q   <= lneg_d;
			lscan_q  <= lscan_d;
			lchars_q <= lchars_d;
			rval_q   <= rval_d;
			rneg_q   <= rneg_d;
			rscan_q  <= rscan_d;
			rchars_q <= rchars_d;
		end
	end

	always_comb begin
		logic clear;
		clear    = 1'b0;
		len_d    = len_q;
		ph_d     = ph_q;
		lval_d   = lval_q;
		lneg_d   = lneg_q;
		lscan_d  = lscan_q;
		lchars_d = lchars_q;
		rval_d   = rval_q;
		rneg_d   = rneg_q;
		rscan_d  = rscan_q;
		rchars_d = rchars_q;

		emit.valid     = 1'b0;
		emit.left_mag  = lval_q;
		emit.right_mag = rval_q;
		emit.left_fwd  = !(lneg_q && (lval_q != '0));
		emit.right_fwd = !(rneg_q && (rval_q != '0));

		if (rx_byte != scfp_pkg::CH_CR && rx_byte != scfp_pkg::CH_LF) begin
			if (len_q == '0) begin
				if (rx_byte == scfp_pkg::CH_V) begin
					clear = 1'b1;
					len_d = LEN_W'(1);
				end
			end else if (len_q >= LEN_LAST) begin
				// buffer full: drop the frame, wait for the closing E
				ph_d = scfp_pkg::PH_DISCARD;
				if (rx_byte == scfp_pkg::CH_E) begin
					len_d = '0;
					clear = 1'b1;
				end
			end else if (rx_byte == scfp_pkg::CH_E) begin
				len_d      = '0;
				emit.valid = (ph_q == scfp_pkg::PH_RIGHT);
				clear      = 1'b1;
			end else begin
				len_d = len_q + LEN_W'(1);
				unique case (ph_q)
					scfp_pkg::PH_LEFT: begin
						if (rx_byte == scfp_pkg::CH_NUL) begin
							ph_d = scfp_pkg::PH_DISCARD;
						end else if (lchars_q >= ONE_CHAR &&
							(rx_byte == scfp_pkg::CH_PLUS || rx_byte == scfp_pkg::CH_MINUS)) begin
							// split: the sign char opens the right part
							ph_d     = (ONE_CHAR > PART_LIM) ? scfp_pkg::PH_DISCARD
								: scfp_pkg::PH_RIGHT;
							rneg_d   = (rx_byte == scfp_pkg::CH_MINUS);
							rscan_d  = scfp_pkg::SC_DIGITS;
							rchars_d = ONE_CHAR;
						end else if (lchars_q >= PART_LIM) begin
							ph_d = scfp_pkg::PH_DISCARD;
						end else begin
							lchars_d = lchars_q + ONE_CHAR;
							case (lscan_q)
								scfp_pkg::SC_BLANKS: begin
									if (scfp_pkg::is_blank(rx_byte)) begin
										lscan_d = scfp_pkg::SC_BLANKS;
									end else if (rx_byte == scfp_pkg::CH_PLUS) begin
										lscan_d = scfp_pkg::SC_DIGITS;
									end else if (rx_byte == scfp_pkg::CH_MINUS) begin
										lneg_d  = 1'b1;
										lscan_d = scfp_pkg::SC_DIGITS;
									end else if (c_digit) begin
										lval_d  = scfp_pkg::acc_digit(lval_q, rx_byte[3:0]);
										lscan_d = scfp_pkg::SC_DIGITS;
									end else begin
										lscan_d = scfp_pkg::SC_STOPPED;
									end
								end
								scfp_pkg::SC_DIGITS: begin
									if (c_digit)
										lval_d = scfp_pkg::acc_digit(lval_q, rx_byte[3:0]);
									else
										lscan_d = scfp_pkg::SC_STOPPED;
								end
								default: begin
									lscan_d = lscan_q;
								end
							endcase
						end
					end
					scfp_pkg::PH_RIGHT: begin
						if (rx_byte == scfp_pkg::CH_NUL) begin
							ph_d = scfp_pkg::PH_DISCARD;
						end else if (rchars_q >= PART_LIM) begin
							ph_d = scfp_pkg::PH_DISCARD;
						end else begin
							rchars_d = rchars_q + ONE_CHAR;
							if (rscan_q == scfp_pkg::SC_DIGITS) begin
								if (c_digit)
									rval_d = scfp_pkg::acc_digit(rval_q, rx_byte[3:0]);
								else
									rscan_d = scfp_pkg::SC_STOPPED;
							end
						end
					end
					default: begin
						ph_d = ph_q;
					end
				endcase
			end
		end

		if (clear) begin
			ph_d     = scfp_pkg::PH_LEFT;
			lval_d   = '0;
			lneg_d   = 1'b0;
			lscan_d  = scfp_pkg::SC_BLANKS;
			lchars_d = '0;
			rval_d   = '0;
			rneg_d   = 1'b0;
			rscan_d  = scfp_pkg::SC_DIGITS;
			rchars_d = '0;
		end
	end

endmodule

// ----- hdl/scfp_scale.sv -----
// Scale register, saturating multipliers and the result output register.
module scfp_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [scfp_pkg::SCALE_W-1:0] cfg_wr_data,
	input  logic                         load,
	input  scfp_pkg::emit_t              emit,
	output logic                         out_free,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [scfp_pkg::MAG_W-1:0]   left_drive,
	output logic [scfp_pkg::MAG_W-1:0]   right_drive,
	output logic                         left_forward,
	output logic                         right_forward
);

	logic [scfp_pkg::SCALE_W-1:0] scale_q;
	logic                         valid_q;
	logic [scfp_pkg::MAG_W-1:0]   ldrive_q, rdrive_q;
	logic                         lfwd_q, rfwd_q;

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= scfp_pkg::SCALE_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				scale_q <= cfg_wr_data;
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ldrive_q <= scfp_pkg::sat_mul(emit.left_mag, scale_q);
			rdrive_q <= scfp_pkg::sat_mul(emit.right_mag, scale_q);
			lfwd_q   <= emit.left_fwd;
			rfwd_q   <= emit.right_fwd;
		end
	end

	assign out_valid     = valid_q;
	assign left_drive    = ldrive_q;
	assign right_drive   = rdrive_q;
	assign left_forward  = lfwd_q;
	assign right_forward = rfwd_q;

endmodule

// ----- hdl/speed_command_frame_parser_top.sv -----
// Top level of the speed command frame parser: input register, parser and result stage.
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[7:0] = rx_byte
//  m_axis    out  tvalid/tready         tdata[31:0] left_drive, [63:32] right_drive;
//                                       tuser[0] left_forward, tuser[1] right_forward
//  cfg       in   cfg_wr_en             cfg_wr_data[7:0] = speed_scale
//
//  One byte per cycle sustained. A byte is held in the input register, where the parser
//  state and, on a closing E, the scale multipliers act on it; a result is registered in the
//  output register on m_axis. Reset clears the frame state and sets speed_scale to 10.
//  Only a closing E that produces a result waits while the output register is full and not
//  taken; every other byte passes through regardless of the output side.
module speed_command_frame_parser_top #(
	parameter int FRAME_MAX = scfp_pkg::FRAME_MAX_DEF,
	parameter int PART_MAX  = scfp_pkg::PART_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,   // [31:0] left_drive, [63:32] right_drive
	output logic [1:0]                   m_axis_tuser,   // [0] left_forward, [1] right_forward
	input  logic                         cfg_wr_en,
	input  logic [scfp_pkg::SCALE_W-1:0] cfg_wr_data
);

	logic                        valid_s1;
	logic [scfp_pkg::BYTE_W-1:0] byte_s1;
	logic                        advance, load, out_free;
	scfp_pkg::emit_t             emit;

	assign advance       = valid_s1 && (!emit.valid || out_free);
	assign load          = advance && emit.valid;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
	end

	scfp_parser #(
		.FRAME_MAX (FRAME_MAX),
		.PART_MAX  (PART_MAX)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.emit    (emit)
	);

	scfp_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.load          (load),
		.emit          (emit),
		.out_free      (out_free),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.left_drive    (m_axis_tdata[31:0]),
		.right_drive   (m_axis_tdata[63:32]),
		.left_forward  (m_axis_tuser[0]),
		.right_forward (m_axis_tuser[1])
	);

	// a result only ever comes from a closing E
	a_emit_on_e: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit.valid) |-> (byte_s1 == scfp_pkg::CH_E))
		else $error("result requested for a byte other than E");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !load)
		else $error("output register overwritten while stalled");

	// a loaded result shows up on the output the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_axis_tvalid)
		else $error("loaded result not presented");

	// a held byte stays put until the parser takes it
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte lost");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the speed command frame parser: byte frames in, scaled drives out.
module tb;
	import scfp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_BYTES = 1220;

	typedef struct packed {
		logic [MAG_W-1:0] left_drive;
		logic [MAG_W-1:0] right_drive;
		logic             left_fwd;
		logic             right_fwd;
	} drive_t;

	// Tracks the frame parser state and queues the drive command each closing E should yield.
	class drive_scoreboard;
		logic [SCALE_W-1:0] scale;
		int unsigned        frame_len;
		phase_t             phase;
		logic [MAG_W-1:0]   left_mag, right_mag;
		bit                 left_neg, right_neg;
		scan_t              left_scan, right_scan;
		int unsigned        left_chars, right_chars;
		drive_t             pending_drives[$];
		int unsigned        n_errors;

		function new();
			scale = SCALE_RESET;
			frame_len = 0;
			n_errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = PH_LEFT;
			left_mag = '0;
			left_neg = 1'b0;
			left_scan = SC_BLANKS;
			left_chars = 0;
			right_mag = '0;
			right_neg = 1'b0;
			right_scan = SC_DIGITS;
			right_chars = 0;
		endfunction

		function bit blank_char(logic [7:0] c);
			return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF ||
				c == CH_CR || c == CH_LF;
		endfunction

		function bit digit_char(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function logic [MAG_W-1:0] push_digit(logic [MAG_W-1:0] v, logic [7:0] c);
			logic [63:0] t;
			t = {32'd0, v} * 64'd10 + {56'd0, c - CH_0};
			return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
		endfunction

		function logic [MAG_W-1:0] scaled_drive(logic [MAG_W-1:0] m);
			logic [63:0] p;
			p = {32'd0, m} * {56'd0, scale};
			return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
		endfunction

		function void body_byte(logic [7:0] c);
			if (phase == PH_DISCARD)
				return;
			if (c == CH_NUL) begin
				phase = PH_DISCARD;
				return;
			end
			if (phase == PH_LEFT) begin
				// a sign after the first left character splits the body
				if (left_chars >= 1 && (c == CH_PLUS || c == CH_MINUS)) begin
					phase = PH_RIGHT;
					right_neg = (c == CH_MINUS);
					right_scan = SC_DIGITS;
					right_chars = 1;
					return;
				end
				if (left_chars >= PART_MAX_DEF) begin
					phase = PH_DISCARD;
					return;
				end
				left_chars++;
				case (left_scan)
					SC_BLANKS: begin
						if (blank_char(c)) begin
						end else if (c == CH_PLUS) begin
							left_scan = SC_DIGITS;
						end else if (c == CH_MINUS) begin
							left_neg = 1'b1;
							left_scan = SC_DIGITS;
						end else if (digit_char(c)) begin
							left_mag = push_digit(left_mag, c);
							left_scan = SC_DIGITS;
						end else begin
							left_scan = SC_STOPPED;
						end
					end
					SC_DIGITS: begin
						if (digit_char(c))
							left_mag = push_digit(left_mag, c);
						else
							left_scan = SC_STOPPED;
					end
					default: begin
					end
				endcase
				return;
			end
			if (right_chars >= PART_MAX_DEF) begin
				phase = PH_DISCARD;
				return;
			end
			right_chars++;
			if (right_scan == SC_DIGITS) begin
				if (digit_char(c))
					right_mag = push_digit(right_mag, c);
				else
					right_scan = SC_STOPPED;
			end
		endfunction

		function void take_byte(logic [7:0] c);
			drive_t d;
			if (c == CH_CR || c == CH_LF)
				return;
			if (frame_len == 0) begin
				if (c != CH_V)
					return;
				clear_frame();
				frame_len = 1;
				return;
			end
			// buffer full: everything is dropped until E closes the frame
			if (frame_len >= FRAME_MAX_DEF - 1) begin
				phase = PH_DISCARD;
				if (c == CH_E) begin
					frame_len = 0;
					clear_frame();
				end
				return;
			end
			frame_len++;
			if (c != CH_E) begin
				body_byte(c);
				return;
			end
			frame_len = 0;
			if (phase == PH_RIGHT) begin
				d.left_drive = scaled_drive(left_mag);
				d.right_drive = scaled_drive(right_mag);
				d.left_fwd = !(left_neg && left_mag != 0);
				d.right_fwd = !(right_neg && right_mag != 0);
				pending_drives.push_back(d);
			end
			clear_frame();
		endfunction

		function void check_drive(logic [63:0] data, logic [1:0] user);
			drive_t d;
			if (pending_drives.size() == 0) begin
				$error("unexpected drive transaction: tdata %h tuser %b", data, user);
				n_errors++;
				return;
			end
			d = pending_drives.pop_front();
			if (data[31:0] !== d.left_drive) begin
				$error("left_drive: expected %0d, got %0d", d.left_drive, data[31:0]);
				n_errors++;
			end
			if (data[63:32] !== d.right_drive) begin
				$error("right_drive: expected %0d, got %0d", d.right_drive, data[63:32]);
				n_errors++;
			end
			if (user[0] !== d.left_fwd) begin
				$error("left_forward: expected %0d, got %0d", d.left_fwd, user[0]);
				n_errors++;
			end
			if (user[1] !== d.right_fwd) begin
				$error("right_forward: expected %0d, got %0d", d.right_fwd, user[1]);
				n_errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'd0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [63:0]        m_axis_tdata;
	logic [1:0]         m_axis_tuser;
	logic               cfg_wr_en = 1'b0;
	logic [SCALE_W-1:0] cfg_wr_data = SCALE_RESET;

	drive_scoreboard sb;
	logic [7:0]      line_q[$];
	bit              calm = 1'b0;
	int unsigned     cycle_count = 0;

	speed_command_frame_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_drive(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.take_byte(s_axis_tdata);
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("speed_command_frame_parser_top test failed");
		$finish;
	end

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endfunction

	function automatic void push_digits(int n);
		for (int i = 0; i < n; i++)
			line_q.push_back(CH_0 + 8'($urandom_range(9)));
	endfunction

	function automatic logic [7:0] any_but_e();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_E)
			b = CH_9;
		return b;
	endfunction

	function automatic logic [7:0] pick_sign();
		return $urandom_range(1) ? CH_PLUS : CH_MINUS;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(3))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	// one frame of random content; mostly well formed, the rest broken in some way
	function automatic void build_frame();
		int kind, nb, ns, nj, nd;
		logic [7:0] b;
		kind = $urandom_range(99);
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom_range(255));
				if (b == CH_V)
					b = CH_SP;
				line_q.push_back(b);
			end
		end
		line_q.push_back(CH_V);
		if (kind < 72) begin
			nb = ($urandom_range(99) < 20) ? $urandom_range(1, 2) : 0;
			ns = ($urandom_range(99) < 60) ? 1 : 0;
			nj = ($urandom_range(99) < 10) ? 1 : 0;
			nd = ($urandom_range(99) < 12) ? PART_MAX_DEF - nb - ns - nj : $urandom_range(1, 4);
			repeat (nb) line_q.push_back(pick_blank());
			if (ns != 0)
				line_q.push_back(pick_sign());
			push_digits(nd);
			if (nj != 0)
				line_q.push_back(any_but_e());
			line_q.push_back(pick_sign());
			nj = ($urandom_range(99) < 10) ? 1 : 0;
			nd = ($urandom_range(99) < 12) ? PART_MAX_DEF - 1 - nj : $urandom_range(0, 4);
			push_digits(nd);
			if (nj != 0)
				line_q.push_back(any_but_e());
			if ($urandom_range(99) < 10)
				line_q.insert($urandom_range(1, line_q.size() - 1),
					$urandom_range(1) ? CH_CR : CH_LF);
		end else if (kind < 78) begin
			push_digits($urandom_range(0, 6));
		end else if (kind < 83) begin
			nb = line_q.size();
			push_digits($urandom_range(1, 3));
			line_q.push_back(pick_sign());
			push_digits($urandom_range(1, 3));
			line_q.insert($urandom_range(nb, line_q.size()), CH_NUL);
		end else if (kind < 88) begin
			if ($urandom_range(1)) begin
				push_digits($urandom_range(10, 12));
				line_q.push_back(pick_sign());
				push_digits($urandom_range(1, 3));
			end else begin
				push_digits($urandom_range(1, 3));
				line_q.push_back(pick_sign());
				push_digits($urandom_range(9, 11));
			end
		end else if (kind < 92) begin
			repeat ($urandom_range(58, 75)) line_q.push_back(any_but_e());
		end else begin
			repeat ($urandom_range(0, 20)) line_q.push_back(any_but_e());
		end
		line_q.push_back(CH_E);
	endfunction

	task automatic transmit();
		logic [7:0] b;
		while (line_q.size() != 0) begin
			b = line_q.pop_front();
			while (!calm && $urandom_range(99) < 28) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
			@(negedge clk);
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= b;
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
		end
	endtask

	// hold the sender until every drive has come out, then let the pipeline empty
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_scale(input logic [SCALE_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.scale = v;
	endtask

	initial begin
		int unsigned frame_bytes;
		int unsigned next_scale_at;
		int unsigned scale_step;
		sb = new();
		frame_bytes = 0;
		next_scale_at = 280;
		scale_step = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames at the reset scale
		push_text("xE9+V12+34E");
		push_text("V-7-8EV-0+0EV+-3E");
		line_q.push_back(CH_V);
		line_q.push_back(CH_SP);
		line_q.push_back(CH_TAB);
		line_q.push_back(CH_VT);
		line_q.push_back(CH_FF);
		push_text("5-6E");
		push_text("V123456789-12345678E");
		push_text("V1234567890+1EV1+123456789E");
		push_text("VEV123E");
		push_text("V1");
		line_q.push_back(CH_NUL);
		push_text("+2E");
		push_text("V1");
		line_q.push_back(CH_CR);
		line_q.push_back(CH_PLUS);
		line_q.push_back(CH_LF);
		push_text("2EVaV+3EV12x+3yE");
		line_q.push_back(CH_V);
		repeat (30) line_q.push_back("1");
		line_q.push_back(CH_PLUS);
		repeat (40) line_q.push_back("2");
		push_text("EV4-4E");
		transmit();
		set_scale(8'd255);
		push_text("V999999999+1EV-5-99999999E");
		transmit();
		set_scale(8'd0);
		push_text("V5-5E");
		transmit();

		while (frame_bytes < RANDOM_BYTES) begin
			calm = (frame_bytes >= 500 && frame_bytes < 750);
			if (frame_bytes >= next_scale_at) begin
				case (scale_step % 4)
					0: set_scale(8'($urandom_range(255)));
					1: set_scale(8'd255);
					2: set_scale(8'($urandom_range(1, 20)));
					default: set_scale(8'd0);
				endcase
				scale_step++;
				next_scale_at += 280;
			end
			build_frame();
			frame_bytes += line_q.size();
			transmit();
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (sb.n_errors == 0)
			$display("speed_command_frame_parser_top test passed");
		else
			$display("speed_command_frame_parser_top test failed");
		$finish;
	end
endmodule

// ----- speed_command_frame_parser_top.f -----
hdl/scfp_pkg.sv
hdl/scfp_parser.sv
hdl/scfp_scale.sv
hdl/speed_command_frame_parser_top.sv
bench/tb.sv
